### hw/rtl/evg_pkg.sv
// Shared types, constants and helpers for the ellipsoid vertex generator.
package evg_pkg;

    localparam int MAX_VERTS_PER_REV = 1024;

    localparam int IDX_W      = 10;
    localparam int VPR_W      = 11;
    localparam int EXT_W      = 16;
    localparam int POS_W      = 16;
    localparam int TEX_W      = 17;
    localparam int ANG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Divider: 26-bit dividend, quotient known to stay below 2^17
    localparam int NUM_W     = 26;
    localparam int QUO_W     = 17;
    localparam int DIV_LANES = 3;

    // Trig datapath: Q30 magnitudes
    localparam int MAG_W     = 31;
    localparam int SIN_LANES = 4;
    localparam int HORNER_N  = 4;
    localparam int TRIG_LAT  = 7;
    localparam int POS_LAT   = 2;
    localparam int LATENCY   = 1 + QUO_W + TRIG_LAT + POS_LAT;

    localparam logic [MAG_W-1:0] Q30_ONE = 31'd1073741824;
    localparam logic [MAG_W-1:0] SIN_C9  = 31'd172272;
    localparam logic [MAG_W-1:0] SIN_C7  = 31'd5026995;
    localparam logic [MAG_W-1:0] SIN_C5  = 31'd85569306;
    localparam logic [MAG_W-1:0] SIN_C3  = 31'd693598669;
    localparam logic [MAG_W-1:0] SIN_C1  = 31'd1686629713;

    localparam logic [MAG_W-1:0] HORNER_C [HORNER_N] = '{SIN_C7, SIN_C5, SIN_C3, SIN_C1};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_DEPTH  = 3'd2,
        CFG_VPR    = 3'd3,
        CFG_TEX_EN = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [IDX_W-1:0] ring_index;
        logic [IDX_W-1:0] step_index;
    } grid_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [TEX_W-1:0]        tex_u;
        logic [TEX_W-1:0]        tex_v;
        logic                    uv_valid;
    } vertex_t;

    typedef struct packed {
        logic             valid;
        logic [MAG_W-1:0] sc_mag;
        logic [MAG_W-1:0] ct_mag;
        logic [MAG_W-1:0] ss_mag;
        logic             sc_neg;
        logic             ct_neg;
        logic             ss_neg;
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
    } trig_t;

    // Q30 product, truncated
    function automatic logic [MAG_W-1:0] mul_q30(input logic [MAG_W-1:0] a,
                                                 input logic [MAG_W-1:0] b);
        logic [2*MAG_W-1:0] p;
        p = a * b;
        return p[MAG_W+29:30];
    endfunction

endpackage

### hw/rtl/evg_div.sv
// Pipelined restoring divider, one quotient bit per stage, three lanes.
module evg_div
    import evg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num [DIV_LANES],
    input  logic [IDX_W-1:0] den,
    output logic             out_valid,
    output logic [QUO_W-1:0] quot [DIV_LANES]
);

    logic [QUO_W-1:0] valid_reg, valid_next;
    logic [NUM_W-1:0] num_reg  [QUO_W][DIV_LANES];
    logic [NUM_W-1:0] num_next [QUO_W][DIV_LANES];
    logic [IDX_W-1:0] rem_reg  [QUO_W][DIV_LANES];
    logic [IDX_W-1:0] rem_next [QUO_W][DIV_LANES];
    logic [QUO_W-1:0] q_reg    [QUO_W][DIV_LANES];
    logic [QUO_W-1:0] q_next   [QUO_W][DIV_LANES];

    // Shift in one dividend bit, subtract the divisor where it fits
    always_comb
    begin
        logic [IDX_W-1:0] r_in;
        logic [NUM_W-1:0] n_in;
        logic [QUO_W-1:0] q_in;
        logic [IDX_W:0]   t;
        valid_next = {valid_reg[QUO_W-2:0], in_valid};
        for (int s = 0; s < QUO_W; s++)
        begin
            for (int l = 0; l < DIV_LANES; l++)
            begin
                if (s == 0)
                begin
                    r_in = IDX_W'(num[l][NUM_W-1:QUO_W]);
                    n_in = num[l];
                    q_in = '0;
                end
                else
                begin
                    r_in = rem_reg[s-1][l];
                    n_in = num_reg[s-1][l];
                    q_in = q_reg[s-1][l];
                end
                t = {r_in, n_in[QUO_W-1-s]};
                num_next[s][l] = n_in;
                if (t >= {1'b0, den})
                begin
                    rem_next[s][l] = IDX_W'(t - {1'b0, den});
                    q_next[s][l]   = {q_in[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[s][l] = t[IDX_W-1:0];
                    q_next[s][l]   = {q_in[QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign out_valid = valid_reg[QUO_W-1];

    always_comb
    begin
        for (int l = 0; l < DIV_LANES; l++)
        begin
            quot[l] = q_reg[QUO_W-1][l];
        end
    end

endmodule

### hw/rtl/evg_trig.sv
// Sine/cosine polynomial pipeline and the sin*cos products.
module evg_trig
    import evg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [ANG_W-1:0] theta,
    input  logic [ANG_W-1:0] phi,
    input  logic [TEX_W-1:0] tex_u,
    input  logic [TEX_W-1:0] tex_v,
    output trig_t            trig
);

    logic [ANG_W-1:0] ang [SIN_LANES];

    logic [TRIG_LAT-1:0] valid_reg;
    logic [TEX_W-1:0]    texu_reg [TRIG_LAT];
    logic [TEX_W-1:0]    texv_reg [TRIG_LAT];
    logic [MAG_W-1:0]    x_reg    [HORNER_N+1][SIN_LANES];
    logic [MAG_W-1:0]    x2_reg   [HORNER_N][SIN_LANES];
    logic                hi_reg   [HORNER_N+1][SIN_LANES];
    logic [MAG_W-1:0]    p_reg    [HORNER_N][SIN_LANES];
    logic [MAG_W-1:0]    mag_reg  [SIN_LANES];
    logic                neg_reg  [SIN_LANES];
    logic [MAG_W-1:0]    sc_reg, ss_reg, ct_reg;
    logic                scn_reg, ssn_reg, ctn_reg;

    // Lane angles: sin theta, cos theta, sin phi, cos phi
    always_comb
    begin
        ang[0] = theta;
        ang[1] = theta + ANG_W'(16384);
        ang[2] = phi;
        ang[3] = phi + ANG_W'(16384);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[TRIG_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        logic [14:0]      f;
        logic [MAG_W-1:0] xv, prod;
        texu_reg[0] <= tex_u;
        texv_reg[0] <= tex_v;
        for (int k = 1; k < TRIG_LAT; k++)
        begin
            texu_reg[k] <= texu_reg[k-1];
            texv_reg[k] <= texv_reg[k-1];
        end
        for (int l = 0; l < SIN_LANES; l++)
        begin
            // Fold into the first quadrant and square
            f = {1'b0, ang[l][13:0]};
            if (ang[l][14])
            begin
                f = 15'd16384 - f;
            end
            xv = {f, 16'b0};
            x_reg[0][l]  <= xv;
            x2_reg[0][l] <= mul_q30(xv, xv);
            hi_reg[0][l] <= ang[l][15];
            // Horner steps
            for (int k = 0; k < HORNER_N; k++)
            begin
                p_reg[k][l] <= HORNER_C[k] -
                    mul_q30((k == 0) ? SIN_C9 : p_reg[(k == 0) ? 0 : k-1][l], x2_reg[k][l]);
                x_reg[k+1][l]  <= x_reg[k][l];
                hi_reg[k+1][l] <= hi_reg[k][l];
            end
            for (int k = 1; k < HORNER_N; k++)
            begin
                x2_reg[k][l] <= x2_reg[k-1][l];
            end
            // Final multiply by x, cap at one
            prod = mul_q30(p_reg[HORNER_N-1][l], x_reg[HORNER_N][l]);
            if (prod > Q30_ONE)
            begin
                prod = Q30_ONE;
            end
            mag_reg[l] <= prod;
            neg_reg[l] <= hi_reg[HORNER_N][l] && (prod != '0);
        end
        // Combine theta and phi terms
        sc_reg  <= mul_q30(mag_reg[0], mag_reg[3]);
        ss_reg  <= mul_q30(mag_reg[0], mag_reg[2]);
        ct_reg  <= mag_reg[1];
        scn_reg <= neg_reg[0] != neg_reg[3];
        ssn_reg <= neg_reg[0] != neg_reg[2];
        ctn_reg <= neg_reg[1];
    end

    always_comb
    begin
        trig.valid  = valid_reg[TRIG_LAT-1];
        trig.sc_mag = sc_reg;
        trig.ct_mag = ct_reg;
        trig.ss_mag = ss_reg;
        trig.sc_neg = scn_reg && (sc_reg != '0);
        trig.ct_neg = ctn_reg;
        trig.ss_neg = ssn_reg && (ss_reg != '0);
        trig.tex_u  = texu_reg[TRIG_LAT-1];
        trig.tex_v  = texv_reg[TRIG_LAT-1];
    end

endmodule

### hw/rtl/evg_pos.sv
// Extent scaling, rounding, saturation and the result register.
module evg_pos
    import evg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  trig_t            trig,
    input  logic [EXT_W-1:0] ext_x,
    input  logic [EXT_W-1:0] ext_y,
    input  logic [EXT_W-1:0] ext_z,
    input  logic             tex_en,
    output logic             done,
    output vertex_t          vertex
);

    localparam int PROD_W = EXT_W + MAG_W + 1;

    logic             v1_reg, done_reg;
    logic [POS_W:0]   m_reg [3];
    logic             n_reg [3];
    logic [TEX_W-1:0] tu_reg, tv_reg;
    vertex_t          vertex_reg;

    function automatic logic [POS_W:0] half_round(input logic [EXT_W-1:0] e,
                                                  input logic [MAG_W-1:0] m);
        logic [PROD_W-1:0] p;
        p = PROD_W'(e) * PROD_W'(m) + PROD_W'(Q30_ONE);
        return p[PROD_W-1:31];
    endfunction

    function automatic logic [POS_W-1:0] sat(input logic [POS_W:0] m, input logic neg);
        logic [POS_W:0] c;
        c = m;
        if (neg)
        begin
            if (c > 17'd32768)
            begin
                c = 17'd32768;
            end
            return POS_W'(17'h10000 - c);
        end
        if (c > 17'd32767)
        begin
            c = 17'd32767;
        end
        return c[POS_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= trig.valid;
            done_reg <= v1_reg;
        end
    end

    // Scale by extents, then saturate into the result register
    always_ff @(posedge clk)
    begin
        m_reg[0] <= half_round(ext_x, trig.sc_mag);
        m_reg[1] <= half_round(ext_y, trig.ct_mag);
        m_reg[2] <= half_round(ext_z, trig.ss_mag);
        n_reg[0] <= trig.sc_neg;
        n_reg[1] <= trig.ct_neg;
        n_reg[2] <= trig.ss_neg;
        tu_reg   <= trig.tex_u;
        tv_reg   <= trig.tex_v;
        vertex_reg.pos_x    <= sat(m_reg[0], n_reg[0]);
        vertex_reg.pos_y    <= sat(m_reg[1], n_reg[1]);
        vertex_reg.pos_z    <= sat(m_reg[2], n_reg[2]);
        vertex_reg.tex_u    <= tex_en ? tu_reg : '0;
        vertex_reg.tex_v    <= tex_en ? tv_reg : '0;
        vertex_reg.uv_valid <= tex_en;
    end

    assign done   = done_reg;
    assign vertex = vertex_reg;

endmodule

### hw/rtl/ellipsoid_vertex_generator_core.sv
// Top level of the ellipsoid vertex generator.
//
// Usage: drive grid (ring and step index) with start; a request is taken at
// every rising edge where start is high and busy is low. busy stays low, so
// one request may enter every clock cycle.
// Each request yields one vertex on the vertex port, marked by done for one
// cycle; the request passes one input stage, 17 divider stages (one quotient
// bit each), 7 trig stages (fold, four Horner multiplies, final multiply,
// sin*cos product) and 2 scaling/saturation stages.
// Results come in request order; the receiver cannot stall and needs none.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data. cfg_ready
// is always high. Write registers only while no request is in flight.
// Reset: rst_n clears the pipeline valid bits and loads the default extents
// (1.0), 32 vertices per revolution and texture coordinates off.
module ellipsoid_vertex_generator_core
    import evg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  grid_t                 grid,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output vertex_t               vertex
);

    logic [EXT_W-1:0] width_reg, height_reg, depth_reg;
    logic [VPR_W-1:0] vpr_reg;
    logic             tex_en_reg;

    logic [VPR_W-1:0] n_clamp;
    logic [IDX_W-1:0] den, ring_c, step_c;
    logic             accept;
    logic             s0_valid_reg;
    logic [NUM_W-1:0] num_reg  [DIV_LANES];
    logic [NUM_W-1:0] num_next [DIV_LANES];
    logic             div_valid;
    logic [QUO_W-1:0] quot [DIV_LANES];
    logic [TEX_W-1:0] tex_u, tex_v;
    trig_t            trig;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= EXT_W'(256);
            height_reg <= EXT_W'(256);
            depth_reg  <= EXT_W'(256);
            vpr_reg    <= VPR_W'(32);
            tex_en_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_DEPTH:  depth_reg  <= cfg_data;
                CFG_VPR:    vpr_reg    <= cfg_data[VPR_W-1:0];
                CFG_TEX_EN: tex_en_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Clamp count and indices, build rounded dividends
    always_comb
    begin
        if (vpr_reg < VPR_W'(2))
        begin
            n_clamp = VPR_W'(2);
        end
        else if (vpr_reg > VPR_W'(MAX_VERTS_PER_REV))
        begin
            n_clamp = VPR_W'(MAX_VERTS_PER_REV);
        end
        else
        begin
            n_clamp = vpr_reg;
        end
        den    = IDX_W'(n_clamp - VPR_W'(1));
        ring_c = (grid.ring_index > den) ? den : grid.ring_index;
        step_c = (grid.step_index > den) ? den : grid.step_index;
        num_next[0] = {1'b0, ring_c, 15'b0} + NUM_W'(den >> 1);
        num_next[1] = {step_c, 16'b0} + NUM_W'(den >> 1);
        num_next[2] = {ring_c, 16'b0} + NUM_W'(den >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
    end

    evg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .num       (num_reg),
        .den       (den),
        .out_valid (div_valid),
        .quot      (quot)
    );

    assign tex_u = TEX_W'(17'h10000 - quot[1]);
    assign tex_v = TEX_W'(17'h10000 - quot[2]);

    evg_trig u_trig (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (div_valid),
        .theta    (quot[0][ANG_W-1:0]),
        .phi      (quot[1][ANG_W-1:0]),
        .tex_u    (tex_u),
        .tex_v    (tex_v),
        .trig     (trig)
    );

    evg_pos u_pos (
        .clk    (clk),
        .rst_n  (rst_n),
        .trig   (trig),
        .ext_x  (width_reg),
        .ext_y  (height_reg),
        .ext_z  (depth_reg),
        .tex_en (tex_en_reg),
        .done   (done),
        .vertex (vertex)
    );

    // Every accepted request yields a done pulse when it leaves the pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("result missing after request");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (vertex.uv_valid == tex_en_reg))
        else $error("uv_valid does not follow texture enable");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !vertex.uv_valid) |-> (vertex.tex_u == '0 && vertex.tex_v == '0))
        else $error("texture coordinates not cleared");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_valid |-> (quot[0] <= QUO_W'(32768) && quot[1] <= QUO_W'(65536)))
        else $error("angle quotient out of range");

endmodule

### sim/tb.sv
// Testbench for the ellipsoid vertex generator: grid requests checked against a local predictor.
`timescale 1ns / 100ps
module tb;
    import evg_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    grid_t                 grid;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  done;
    vertex_t               vertex;

    // shadow registers
    logic [15:0] ext_w, ext_h, ext_d;
    logic [10:0] verts_rev;
    logic        tex_on;

    grid_t   grid_q[$];
    vertex_t vertex_q[$];
    int      mismatches;
    int      cycles;
    int      burst_left;
    int      gap_left;
    bit      hold_send;
    int      sent_count;

    ellipsoid_vertex_generator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .grid      (grid),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .vertex    (vertex)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
        return (a * b) >> 30;
    endfunction

    // sine of a 16-bit turn angle, magnitude in Q30; returns sign
    function automatic bit turn_sine(longint unsigned ang, output longint unsigned mag);
        longint unsigned a, quad, f, x, x2, p;
        a    = ang & 64'hFFFF;
        quad = a >> 14;
        f    = a & 64'h3FFF;
        if (quad[0])
            f = 16384 - f;
        x  = f << 16;
        x2 = q30_mul(x, x);
        p  = SIN_C9;
        p  = SIN_C7 - q30_mul(p, x2);
        p  = SIN_C5 - q30_mul(p, x2);
        p  = SIN_C3 - q30_mul(p, x2);
        p  = SIN_C1 - q30_mul(p, x2);
        p  = q30_mul(p, x);
        if (p > Q30_ONE)
            p = Q30_ONE;
        mag = p;
        return (quad >= 2) && (p != 0);
    endfunction

    function automatic logic [15:0] scale_pos(longint unsigned ext, longint unsigned mag, bit neg);
        longint unsigned m;
        m = (ext * mag + Q30_ONE) >> 31;
        if (neg)
        begin
            if (m > 32768)
                m = 32768;
            return 16'((64'h10000 - m) & 64'hFFFF);
        end
        if (m > 32767)
            m = 32767;
        return 16'(m);
    endfunction

    function automatic vertex_t predict_vertex(grid_t g);
        longint unsigned n, den, ring, stp, th, ph, st, ct, sp, cp, sc, ss, pu, pv;
        bit nst, nct, nsp, ncp;
        vertex_t v;
        n = verts_rev;
        if (n < 2)
            n = 2;
        if (n > MAX_VERTS_PER_REV)
            n = MAX_VERTS_PER_REV;
        den  = n - 1;
        ring = g.ring_index;
        stp  = g.step_index;
        if (ring > den)
            ring = den;
        if (stp > den)
            stp = den;
        th  = (ring * 32768 + den / 2) / den;
        pu  = (stp * 65536 + den / 2) / den;
        pv  = (ring * 65536 + den / 2) / den;
        ph  = pu & 64'hFFFF;
        nst = turn_sine(th, st);
        nct = turn_sine(th + 16384, ct);
        nsp = turn_sine(ph, sp);
        ncp = turn_sine(ph + 16384, cp);
        sc  = q30_mul(st, cp);
        ss  = q30_mul(st, sp);
        v.pos_x = scale_pos(ext_w, sc, (nst != ncp) && sc != 0);
        v.pos_y = scale_pos(ext_h, ct, nct);
        v.pos_z = scale_pos(ext_d, ss, (nst != nsp) && ss != 0);
        if (tex_on)
        begin
            v.tex_u    = 17'((65536 - pu) & 64'h1FFFF);
            v.tex_v    = 17'((65536 - pv) & 64'h1FFFF);
            v.uv_valid = 1'b1;
        end
        else
        begin
            v.tex_u    = '0;
            v.tex_v    = '0;
            v.uv_valid = 1'b0;
        end
        return v;
    endfunction

    // write one register and mirror it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WIDTH:  ext_w = val;
            CFG_HEIGHT: ext_h = val;
            CFG_DEPTH:  ext_d = val;
            CFG_VPR:    verts_rev = val[10:0];
            CFG_TEX_EN: tex_on = val[0];
            default: ;
        endcase
    endtask

    task automatic set_all(logic [15:0] w, logic [15:0] h, logic [15:0] d,
                           logic [15:0] n, logic [15:0] t);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_DEPTH, d);
        write_reg(CFG_VPR, n);
        write_reg(CFG_TEX_EN, t);
    endtask

    task automatic wait_idle();
        while (grid_q.size() != 0 || vertex_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_grid(int r, int s);
        grid_t g;
        g.ring_index = 10'(r);
        g.step_index = 10'(s);
        grid_q = {grid_q, g};
    endtask

    task automatic random_items(int count, int maxidx);
        repeat (count)
        begin
            if ($urandom_range(0, 9) == 0)
                push_grid($urandom_range(0, 1023), $urandom_range(0, 1023));
            else
                push_grid($urandom_range(0, maxidx), $urandom_range(0, maxidx));
        end
    endtask

    // driver: bursts and gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            grid       <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                vertex_q = {vertex_q, predict_vertex(grid)};
                void'(grid_q.pop_front());
                sent_count <= sent_count + 1;
            end
            if (start && busy)
                ;
            else if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (!hold_send && grid_q.size() > 0)
            begin
                start <= 1'b1;
                grid  <= grid_q[0];
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: compare each vertex with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (vertex_q.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected vertex %h", vertex);
            end
            else
            begin
                if (vertex !== vertex_q[0])
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display({"vertex mismatch: exp x=%0d y=%0d z=%0d u=%0d v=%0d ",
                                  "uv=%0b, got x=%0d y=%0d z=%0d u=%0d v=%0d uv=%0b"},
                            vertex_q[0].pos_x, vertex_q[0].pos_y, vertex_q[0].pos_z,
                            vertex_q[0].tex_u, vertex_q[0].tex_v, vertex_q[0].uv_valid,
                            vertex.pos_x, vertex.pos_y, vertex.pos_z,
                            vertex.tex_u, vertex.tex_v, vertex.uv_valid);
                end
                void'(vertex_q.pop_front());
            end
        end
    end

    // timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        mismatches = 0;
        cycles     = 0;
        hold_send  = 1'b0;
        sent_count = 0;
        ext_w = 16'd256; ext_h = 16'd256; ext_d = 16'd256;
        verts_rev = 11'd32; tex_on = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed at reset values: corners, clamping, quadrants
        push_grid(0, 0);
        push_grid(31, 31);
        push_grid(1023, 1023);
        push_grid(16, 8);
        push_grid(16, 24);
        push_grid(8, 16);
        push_grid(682, 341);
        wait_idle();

        // full extents with texcoords; saturation at the equator
        set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1024, 16'd1);
        push_grid(0, 0);
        push_grid(1023, 1023);
        push_grid(511, 0);
        push_grid(511, 256);
        push_grid(511, 767);
        push_grid(341, 682);
        push_grid(1023, 512);
        wait_idle();

        // smallest and out-of-range counts, zero extents, unused index ignored
        set_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
        write_reg(CFG_UNUSED, 16'hFFFF);
        push_grid(0, 1);
        push_grid(1, 0);
        push_grid(1023, 1023);
        wait_idle();
        write_reg(CFG_WIDTH, 16'h1234);
        write_reg(CFG_VPR, 16'd1);
        push_grid(1, 1);
        wait_idle();
        write_reg(CFG_VPR, 16'd2047);
        push_grid(1023, 600);
        push_grid(700, 1023);
        wait_idle();

        // random phases over several settings
        set_all(16'd256, 16'd512, 16'd1024, 16'd32, 16'd1);
        random_items(250, 40);
        wait_idle();
        set_all(16'($urandom), 16'($urandom), 16'($urandom), 16'd1024, 16'd0);
        random_items(250, 1023);
        // pause the sender until every result has come
        wait (sent_count >= 275);
        hold_send = 1'b1;
        while (vertex_q.size() != 0)
            @(posedge clk);
        hold_send = 1'b0;
        wait_idle();
        set_all(16'hFFFF, 16'd0, 16'h8000, 16'($urandom_range(2, 200)), 16'd1);
        random_items(300, 255);
        wait_idle();
        set_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(0, 2047)), 16'd1);
        random_items(280, 1023);
        wait_idle();

        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

### filelist.f
hw/rtl/evg_pkg.sv
hw/rtl/evg_div.sv
hw/rtl/evg_trig.sv
hw/rtl/evg_pos.sv
hw/rtl/ellipsoid_vertex_generator_core.sv
sim/tb.sv
